// File: sv/hid_keyboard_report_to_key_events_defines.svh
// Assertion macros shared by the key event converter modules.
`ifndef HID_KEYBOARD_REPORT_TO_KEY_EVENTS_DEFINES_SVH
`define HID_KEYBOARD_REPORT_TO_KEY_EVENTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKRE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HKRE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hkre_pkg.sv
package hkre_pkg;

    localparam int KEY_SLOTS_DEF     = 6;
    localparam int INPUT_SLOT_FIELDS = 6;
    localparam int MAX_EVENTS        = 20;
    localparam int FIRST_KEY         = 4;
    localparam int KEY_LIMIT         = 232;
    localparam int MOD_BASE          = 224;
    localparam int MOD_BITS          = 8;
    localparam int MOD_IDX_W         = 3;
    localparam int CODE_W            = 8;
    localparam int TIME_W            = 64;
    localparam int CNT_W             = $clog2(MAX_EVENTS + 1);

    localparam int S_TDATA_W = MOD_BITS + INPUT_SLOT_FIELDS * CODE_W + TIME_W;
    localparam int M_TDATA_W = CODE_W + TIME_W;
    localparam int TIME_LSB  = MOD_BITS + INPUT_SLOT_FIELDS * CODE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } hkre_state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic load_next;
        logic commit;
    } hkre_cmd_t;

    typedef struct packed {
        logic enabled;
        logic scan_empty;
        logic out_last;
    } hkre_status_t;

    function automatic logic key_ok(input logic [CODE_W-1:0] code);
        return (code >= CODE_W'(FIRST_KEY)) && (code < CODE_W'(KEY_LIMIT));
    endfunction

endpackage

// File: sv/hkre_ctrl.sv
`include "hid_keyboard_report_to_key_events_defines.svh"

module hkre_ctrl
    import hkre_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  hkre_status_t status,
    output hkre_cmd_t    cmd
);

    hkre_state_t state_reg;
    hkre_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && status.enabled) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_empty) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (status.out_last) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.load_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `HKRE_ASSERT_NEXT(a_capture_to_scan, aclk, aresetn, cmd.capture, state_reg == ST_SCAN, "capture not followed by scan")
    `HKRE_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, state_reg == ST_EMIT, "stalled word dropped")
    `HKRE_ASSERT_NEXT(a_commit_idle, aclk, aresetn, cmd.commit, state_reg == ST_IDLE, "commit without return to idle")

endmodule

// File: sv/hkre_datapath.sv
`include "hid_keyboard_report_to_key_events_defines.svh"

module hkre_datapath
    import hkre_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 cfg_valid,
    input  logic [0:0]           cfg_data,
    input  hkre_cmd_t            cmd,
    output hkre_status_t         status,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int NV     = MOD_BITS + 2 * KEY_SLOTS;
    localparam int IDX_W  = $clog2(NV);
    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic                  enabled_reg;
    logic [MOD_BITS-1:0]   cur_mods_reg;
    logic [MOD_BITS-1:0]   prev_mods_reg;
    logic [CODE_W-1:0]     cur_slots_reg  [KEY_SLOTS];
    logic [CODE_W-1:0]     prev_slots_reg [KEY_SLOTS];
    logic [TIME_W-1:0]     time_reg;
    logic [NV-1:0]         pending_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CODE_W-1:0]     out_code_reg;
    logic                  out_pressed_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic                  out_last_reg;

    logic [CODE_W-1:0]     in_slot [KEY_SLOTS];
    logic [KEY_SLOTS-1:0]  rel_vec;
    logic [KEY_SLOTS-1:0]  prs_vec;
    logic [NV-1:0]         cmp_vec;
    logic [NV-1:0]         src_vec;
    logic [NV-1:0]         low_vec;
    logic [NV-1:0]         rest_vec;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      off;
    logic [IDX_W-1:0]      off_prs;
    logic [CNT_W-1:0]      cnt_base;
    logic [CODE_W-1:0]     ev_code;
    logic                  ev_pressed;
    logic                  ev_last;
    logic                  load;

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_in_slot
        if (g < INPUT_SLOT_FIELDS) begin : g_field
            assign in_slot[g] = s_tdata[MOD_BITS + g * CODE_W +: CODE_W];
        end else begin : g_empty
            assign in_slot[g] = '0;
        end
    end

    always_comb begin
        logic prev_in_cur;
        logic cur_in_prev;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            prev_in_cur = 1'b0;
            cur_in_prev = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                prev_in_cur = prev_in_cur | (cur_slots_reg[j] == prev_slots_reg[i]);
                cur_in_prev = cur_in_prev | (prev_slots_reg[j] == cur_slots_reg[i]);
            end
            rel_vec[i] = !prev_in_cur && key_ok(prev_slots_reg[i]);
            prs_vec[i] = !cur_in_prev && key_ok(cur_slots_reg[i]);
        end
    end

    assign cmp_vec  = {prs_vec, rel_vec, cur_mods_reg ^ prev_mods_reg};
    assign src_vec  = cmd.scan ? cmp_vec : pending_reg;
    assign low_vec  = src_vec & (~src_vec + NV'(1));
    assign rest_vec = src_vec & ~low_vec;
    assign cnt_base = cmd.scan ? '0 : count_reg;

    always_comb begin
        idx = '0;
        for (int i = 0; i < NV; i++) begin
            if (low_vec[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
    end

    assign off     = idx - IDX_W'(MOD_BITS);
    assign off_prs = off - IDX_W'(KEY_SLOTS);

    always_comb begin
        if (idx < IDX_W'(MOD_BITS)) begin
            ev_code    = CODE_W'(MOD_BASE) + CODE_W'(idx[MOD_IDX_W-1:0]);
            ev_pressed = cur_mods_reg[idx[MOD_IDX_W-1:0]];
        end else if (off < IDX_W'(KEY_SLOTS)) begin
            ev_code    = prev_slots_reg[off[SLOT_W-1:0]];
            ev_pressed = 1'b0;
        end else begin
            ev_code    = cur_slots_reg[off_prs[SLOT_W-1:0]];
            ev_pressed = 1'b1;
        end
    end

    assign ev_last = (rest_vec == '0) || (cnt_base == CNT_W'(MAX_EVENTS - 1));
    assign load    = (cmd.scan && (cmp_vec != '0)) || cmd.load_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            prev_mods_reg <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                prev_slots_reg[i] <= '0;
            end
            pending_reg   <= '0;
            count_reg     <= '0;
            out_last_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                enabled_reg <= cfg_data[0];
            end
            if (cmd.commit) begin
                prev_mods_reg <= cur_mods_reg;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    prev_slots_reg[i] <= cur_slots_reg[i];
                end
            end
            if (load) begin
                pending_reg  <= rest_vec;
                count_reg    <= cnt_base + CNT_W'(1);
                out_last_reg <= ev_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_mods_reg <= s_tdata[MOD_BITS-1:0];
            for (int i = 0; i < KEY_SLOTS; i++) begin
                cur_slots_reg[i] <= in_slot[i];
            end
            time_reg <= s_tdata[TIME_LSB +: TIME_W];
        end
        if (load) begin
            out_code_reg    <= ev_code;
            out_pressed_reg <= ev_pressed;
            out_time_reg    <= time_reg;
        end
    end

    assign status.enabled    = enabled_reg;
    assign status.scan_empty = (cmp_vec == '0);
    assign status.out_last   = out_last_reg;

    assign m_tdata = {out_time_reg, out_code_reg};
    assign m_tuser = out_pressed_reg;
    assign m_tlast = out_last_reg;

    `HKRE_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_EVENTS), "event count beyond limit")
    `HKRE_ASSERT_NEXT(a_first_count, aclk, aresetn, cmd.scan && !status.scan_empty, count_reg == CNT_W'(1), "first event not counted")
    `HKRE_ASSERT_NEXT(a_commit_mods, aclk, aresetn, cmd.commit, prev_mods_reg == $past(cur_mods_reg), "modifier state not committed")

endmodule

// File: sv/hid_keyboard_report_to_key_events.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: report (modifiers, key slots, time)
// m_        out        m_tvalid / m_tready    m_tdata, m_tuser, m_tlast: one key event
// cfg_      in         cfg_valid / cfg_ready  cfg_data: key events enable
//
// A report with events is taken into the capture registers, its slots are compared with the
// previous ones, then one event per cycle leaves the output register while m_tready is high.
// A report with no events ends at the comparison; one sent while disabled is dropped.
// A stall on m_ holds the current event and keeps s_tready low until the last is taken.
// Reset clears the enable, the previous modifiers and the previous key slots.
module hid_keyboard_report_to_key_events
    import hkre_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Fields from bit 0: modifier_bits, key_slot0..key_slot5, report_time.
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: scancode, event_time.
    output logic [M_TDATA_W-1:0] m_tdata,
    // Fields from bit 0: pressed.
    output logic [0:0]           m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [0:0]           cfg_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready
);

    hkre_cmd_t    cmd;
    hkre_status_t status;

    assign cfg_ready = 1'b1;

    hkre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hkre_datapath #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: bench/hid_keyboard_report_to_key_events_tb.sv
module hid_keyboard_report_to_key_events_tb;
    import hkre_pkg::*;

    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [TIME_W-1:0]                             stamp;
        logic [INPUT_SLOT_FIELDS-1:0][CODE_W-1:0]      keys;
        logic [MOD_BITS-1:0]                           mods;
    } report_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              down;
        logic [TIME_W-1:0] stamp;
        logic              last;
    } key_event_t;

    class key_event_scoreboard;
        bit                                        enabled;
        bit [MOD_BITS-1:0]                         held_mods;
        bit [INPUT_SLOT_FIELDS-1:0][CODE_W-1:0]    held_keys;
        key_event_t                                expected_events[$];
        int errors;
        int events_checked;
        int reports_seen;
        int reports_dropped;
        int most_events;

        function bit in_slots(logic [INPUT_SLOT_FIELDS-1:0][CODE_W-1:0] slots,
                              logic [CODE_W-1:0] code);
            for (int i = 0; i < INPUT_SLOT_FIELDS; i++) begin
                if (slots[i] == code) return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit emits(logic [CODE_W-1:0] code);
            return code >= CODE_W'(FIRST_KEY) && code < CODE_W'(KEY_LIMIT);
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void note_report(report_t r);
            key_event_t          batch[MAX_EVENTS];
            int                  n;
            logic [MOD_BITS-1:0] flips;
            logic [CODE_W-1:0]   k;
            reports_seen++;
            if (!enabled) begin
                reports_dropped++;
                return;
            end
            n = 0;
            flips = held_mods ^ r.mods;
            for (int b = 0; b < MOD_BITS; b++) begin
                if (flips[b]) begin
                    batch[n] = '{CODE_W'(MOD_BASE + b), r.mods[b], r.stamp, 1'b0};
                    n++;
                end
            end
            for (int i = 0; i < INPUT_SLOT_FIELDS; i++) begin
                k = held_keys[i];
                if (k != 0 && !in_slots(r.keys, k) && emits(k) && n < MAX_EVENTS) begin
                    batch[n] = '{k, 1'b0, r.stamp, 1'b0};
                    n++;
                end
            end
            for (int i = 0; i < INPUT_SLOT_FIELDS; i++) begin
                k = r.keys[i];
                if (k != 0 && !in_slots(held_keys, k) && emits(k) && n < MAX_EVENTS) begin
                    batch[n] = '{k, 1'b1, r.stamp, 1'b0};
                    n++;
                end
            end
            held_mods = r.mods;
            held_keys = r.keys;
            if (n > 0) batch[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) expected_events.push_back(batch[i]);
            if (n > most_events) most_events = n;
        endfunction

        function void check_event(key_event_t got);
            key_event_t want;
            if (expected_events.size() == 0) begin
                $error("unexpected key event: scancode %0d pressed %0b event_time %h",
                       got.code, got.down, got.stamp);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            if (got.code !== want.code) begin
                $error("scancode: expected %0d, actual %0d", want.code, got.code);
                errors++;
            end
            if (got.down !== want.down) begin
                $error("pressed: expected %0b, actual %0b", want.down, got.down);
                errors++;
            end
            if (got.stamp !== want.stamp) begin
                $error("event_time: expected %h, actual %h", want.stamp, got.stamp);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_event: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [0:0]           cfg_data = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    key_event_scoreboard sb = new();
    report_t             last_report = '0;
    key_event_t          seen_event;
    int                  burst_left = 0;
    int                  enable_writes = 0;
    bit                  start_hold = 1'b0;
    bit                  hold_done = 1'b0;
    int                  hold_left = 0;
    int                  rx_cycle = 0;
    int                  rx_mode = 0;

    hid_keyboard_report_to_key_events u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
        if (start_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                2: m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = (rx_cycle % 3 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_event.code  = m_tdata[CODE_W-1:0];
            seen_event.stamp = m_tdata[CODE_W +: TIME_W];
            seen_event.down  = m_tuser[0];
            seen_event.last  = m_tlast;
            sb.check_event(seen_event);
        end
    end

    function automatic logic [CODE_W-1:0] pick_code();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return '0;
        if (sel < 85) return CODE_W'($urandom_range(FIRST_KEY, KEY_LIMIT - 1));
        if (sel < 92) return CODE_W'($urandom_range(1, FIRST_KEY - 1));
        return CODE_W'($urandom_range(KEY_LIMIT, 255));
    endfunction

    // Most reports follow a typing pattern: a few keys and modifiers change at a time.
    function automatic report_t next_report(input report_t prev);
        report_t r;
        int      style;
        int      slot;
        r = prev;
        r.stamp = {$urandom, $urandom};
        style = $urandom_range(0, 99);
        if (style < 60) begin
            repeat ($urandom_range(0, 2)) r.mods[$urandom_range(0, MOD_BITS - 1)] ^= 1'b1;
            repeat ($urandom_range(0, 3)) begin
                slot = $urandom_range(0, INPUT_SLOT_FIELDS - 1);
                if ($urandom_range(0, 7) == 0)
                    r.keys[slot] = r.keys[$urandom_range(0, INPUT_SLOT_FIELDS - 1)];
                else
                    r.keys[slot] = pick_code();
            end
        end else if (style < 78) begin
            r.mods = MOD_BITS'($urandom);
            r.keys = {16'($urandom), $urandom};
        end else if (style < 90) begin
            r.mods = MOD_BITS'($urandom);
            for (int i = 0; i < INPUT_SLOT_FIELDS; i++) r.keys[i] = pick_code();
        end
        return r;
    endfunction

    function automatic report_t make_report(input logic [MOD_BITS-1:0] mods,
                                            input logic [47:0] keys,
                                            input logic [TIME_W-1:0] stamp);
        report_t r;
        r.mods  = mods;
        r.keys  = keys;
        r.stamp = stamp;
        return r;
    endfunction

    task automatic send_report(input report_t r);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  = r;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_report(r);
        last_report = r;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_report(next_report(last_report));
    endtask

    task automatic write_enable(input bit value);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.enabled = value;
        enable_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("hid_keyboard_report_to_key_events verification failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reports before the first enable must leave the previous state at zero.
        send_random(6);
        write_enable(1'b1);

        send_report(make_report(8'h00, 48'h00_00_00_00_00_00, 64'h0));
        send_report(make_report(8'hFF, 48'h09_08_07_06_05_04, 64'h0));
        send_report(make_report(8'h00, 48'h00_00_00_00_00_00, 64'hFFFF_FFFF_FFFF_FFFF));
        send_report(make_report(8'h00, 48'h09_08_07_06_05_04, 64'h1));
        send_report(make_report(8'hFF, 48'h0F_0E_0D_0C_0B_0A, 64'hA5A5_A5A5_A5A5_A5A5));
        send_report(make_report(8'hFF, 48'h0F_0E_0D_0C_0B_0A, 64'h5A5A_5A5A_5A5A_5A5A));
        send_report(make_report(8'h00, 48'h00_00_00_00_00_00, 64'h8000_0000_0000_0000));
        send_report(make_report(8'h00, 48'hE7_FF_E8_03_02_01, 64'h2));
        send_report(make_report(8'h00, 48'h01_02_03_E8_FF_E7, 64'h3));
        send_report(make_report(8'h00, 48'h00_00_00_00_00_00, 64'h4));
        send_report(make_report(8'h00, 48'h00_00_00_00_0A_0A, 64'h5));
        send_report(make_report(8'h00, 48'h00_00_00_00_00_00, 64'h6));
        send_report(make_report(8'h01, 48'h00_00_00_00_00_00, 64'h7));
        send_report(make_report(8'h80, 48'h00_00_00_00_00_00, 64'h8));
        send_report(make_report(8'h00, 48'h00_00_00_00_E7_04, 64'h9));
        send_report(make_report(8'hAA, 48'h00_00_00_00_00_03, 64'hA));
        send_report(make_report(8'h55, 48'h00_00_00_00_00_03, 64'hB));
        send_report(make_report(8'h00, 48'h00_00_00_00_00_00, 64'hC));

        send_random(150);

        // While disabled the block must drop reports and keep the held keys.
        write_enable(1'b0);
        send_random(10);
        write_enable(1'b1);

        start_hold = 1'b1;
        send_random(40);

        send_random(150);
        write_enable(1'b0);
        send_random(4);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Run covered %0d reports (%0d dropped while key events were off)",
                 sb.reports_seen, sb.reports_dropped);
        $display("and %0d key events; enable written %0d times; largest report gave %0d events.",
                 sb.events_checked, enable_writes, sb.most_events);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("hid_keyboard_report_to_key_events verification clean");
        end else begin
            $display("hid_keyboard_report_to_key_events verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/hkre_pkg.sv
sv/hkre_ctrl.sv
sv/hkre_datapath.sv
sv/hid_keyboard_report_to_key_events.sv
bench/hid_keyboard_report_to_key_events_tb.sv
